[hdl/rsi_pkg.sv]
`timescale 1ns / 1ps

package rsi_pkg;

  localparam int FRAC_BITS = 16;
  // signed width that holds A, H, C and the hit point for any fraction width
  localparam int W  = 68 - FRAC_BITS;
  localparam int HW = (W + 1) / 2;
  localparam int QW = 4 * HW;
  localparam int PW = 2 * W;
  localparam int QB = 33;
  localparam int NW = W + 1 + FRAC_BITS;
  localparam int RW = 31;
  localparam int TDIV_LAT = QB + 2;

  localparam logic signed [31:0] SAT_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;
  localparam logic signed [FRAC_BITS+1:0] N_ONE = {2'b01, {FRAC_BITS{1'b0}}};

  typedef enum logic [1:0] {
    REG_CENTRE_X,
    REG_CENTRE_Y,
    REG_CENTRE_Z,
    REG_RADIUS
  } cfg_idx_t;

  typedef logic signed [W-1:0] sw_t;
  typedef logic [2:0][31:0] vec3_t;

  typedef struct packed {
    vec3_t       o;
    vec3_t       d;
    logic [31:0] tmin;
    logic [31:0] tmax;
  } ray_t;

  typedef struct packed {
    logic         miss;
    logic [W-1:0] a;
    logic [W-1:0] h;
    ray_t         ray;
  } mid_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] t;
    vec3_t       p;
    vec3_t       d;
  } back_t;

  function automatic logic signed [31:0] sat32(input logic signed [W-1:0] x);
    logic signed [31:0] r;
    if (x > sw_t'(SAT_MAX)) begin
      r = SAT_MAX;
    end else if (x < sw_t'(SAT_MIN)) begin
      r = SAT_MIN;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

[hdl/rsi_sqrt.sv]
`timescale 1ns / 1ps

module rsi_sqrt import rsi_pkg::*; (
  input  logic          clk,
  input  logic          en,
  input  logic [PW-1:0] rad,
  output logic [W-1:0]  root
);

  logic [W+1:0]  rem_r  [W];
  logic [W-1:0]  root_r [W];
  logic [PW-1:0] x_r    [W];

  for (genvar k = 0; k < W; k++) begin : g_st
    logic [W+1:0]  rem_p;
    logic [W-1:0]  root_p;
    logic [PW-1:0] x_p;
    logic [W+1:0]  rem_sh;
    logic [W+1:0]  trial;
    logic          ge;

    if (k == 0) begin : g_first
      assign rem_p  = '0;
      assign root_p = '0;
      assign x_p    = rad;
    end else begin : g_next
      assign rem_p  = rem_r[k-1];
      assign root_p = root_r[k-1];
      assign x_p    = x_r[k-1];
    end

    // one result bit per stage, two radicand bits shifted in
    assign rem_sh = {rem_p[W-1:0], x_p[PW-1 -: 2]};
    assign trial  = {root_p, 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= ge ? rem_sh - trial : rem_sh;
        root_r[k] <= {root_p[W-2:0], ge};
        x_r[k]    <= {x_p[PW-3:0], 2'b00};
      end
    end
  end

  assign root = root_r[W-1];

endmodule

[hdl/rsi_tdiv.sv]
`timescale 1ns / 1ps

module rsi_tdiv import rsi_pkg::*; (
  input  logic                clk,
  input  logic                en,
  input  logic signed [W:0]   num,
  input  logic [W-1:0]        den,
  output logic signed [31:0]  t
);

  logic [W:0]    mg;
  logic [NW-1:0] nsh;
  logic [NW-1:0] hiv;
  logic          ovf;

  logic [W-1:0]  rem_r [QB+1];
  logic [QB-1:0] low_r [QB+1];
  logic [QB-1:0] q_r   [QB+1];
  logic [W-1:0]  den_r [QB+1];
  logic [QB:0]   neg_r;
  logic [QB:0]   ovf_r;
  logic signed [31:0] t_nxt;
  logic signed [31:0] t_r;

  assign mg  = num[W] ? $unsigned(-num) : $unsigned(num);
  assign nsh = {mg, {FRAC_BITS{1'b0}}};
  assign hiv = nsh >> QB;
  // quotient of 2^QB or more saturates whatever the sign
  assign ovf = hiv >= NW'(den);

  always_comb begin
    if (ovf_r[QB]) begin
      t_nxt = neg_r[QB] ? SAT_MIN : SAT_MAX;
    end else if (neg_r[QB]) begin
      t_nxt = (q_r[QB] > QB'(32'h8000_0000)) ? SAT_MIN : 32'(-$signed({1'b0, q_r[QB]}));
    end else begin
      t_nxt = (q_r[QB] > QB'(32'h7fff_ffff)) ? SAT_MAX : $signed(q_r[QB][31:0]);
    end
  end

  always_ff @(posedge clk) begin : p_div
    logic [W:0] rsh;
    logic       ge;
    if (en) begin
      rem_r[0] <= W'(hiv);
      low_r[0] <= nsh[QB-1:0];
      q_r[0]   <= '0;
      den_r[0] <= den;
      neg_r[0] <= num[W];
      ovf_r[0] <= ovf;
      for (int j = 1; j <= QB; j++) begin
        rsh = {rem_r[j-1], low_r[j-1][QB-1]};
        ge  = rsh >= {1'b0, den_r[j-1]};
        rem_r[j] <= ge ? W'(rsh - {1'b0, den_r[j-1]}) : W'(rsh);
        low_r[j] <= low_r[j-1] << 1;
        q_r[j]   <= {q_r[j-1][QB-2:0], ge};
        den_r[j] <= den_r[j-1];
        neg_r[j] <= neg_r[j-1];
        ovf_r[j] <= ovf_r[j-1];
      end
      t_r <= t_nxt;
    end
  end

  assign t = t_r;

endmodule

[hdl/ray_sphere_intersect_core.sv]
`timescale 1ns / 1ps
// Pipeline: an input transfer reaches out_valid through the shift-subtract
//   square root (one root bit per stage) and the two divides.
// Throughput: one ray per cycle; the whole pipe advances unless a held
//   result is stalled at the output register.
// Reset (rst_n, synchronous): clears all valid bits, centre to 0, radius 1.0.
module ray_sphere_intersect_core import rsi_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_origin_x,
  input  logic signed [31:0] in_origin_y,
  input  logic signed [31:0] in_origin_z,
  input  logic signed [31:0] in_dir_x,
  input  logic signed [31:0] in_dir_y,
  input  logic signed [31:0] in_dir_z,
  input  logic signed [31:0] in_t_min,
  input  logic signed [31:0] in_t_max,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_hit_found,
  output logic signed [31:0] out_t_hit,
  output logic signed [31:0] out_point_x,
  output logic signed [31:0] out_point_y,
  output logic signed [31:0] out_point_z,
  output logic signed [17:0] out_normal_x,
  output logic signed [17:0] out_normal_y,
  output logic signed [17:0] out_normal_z,
  output logic               out_front_face,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  logic en;
  logic signed [31:0] cx_r, cy_r, cz_r;
  logic [RW-1:0]      rad_r;
  logic signed [31:0] cen [3];

  // front end
  ray_t ray_in;
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  ray_t ray1_r, ray2_r, ray3_r, ray4_r, ray5_r;
  logic signed [32:0] m1_r [3];
  logic [32:0]        mmag [3];
  logic [63:0]        dd2_r [3];
  logic signed [65:0] dm2_r [3];
  logic [65:0]        mm2_r [3];
  logic [61:0]        rr2_r;
  logic [W-1:0]       a_nxt, msq;
  sw_t                h_nxt, cc_nxt;
  logic [W-1:0]       a3_r, a4_r, a5_r;
  sw_t                h3_r, h4_r, h5_r, cc3_r;
  logic [W-1:0]       habs, cabs;
  logic [HW-1:0]      h_lo, h_hi, a_lo, a_hi, c_lo, c_hi;
  logic [2*HW-1:0]    hll4_r, hlh4_r, hhh4_r, all4_r, alh4_r, ahl4_r, ahh4_r;
  logic               apos4_r, ccpos4_r, apos5_r, ccpos5_r;
  logic [QW-1:0]      hh5_r, ac5_r;
  logic [PW-1:0]      disc6_r;
  mid_t               sb6_r;

  // root and divide
  logic [W-1:0]       sq;
  mid_t               sqd_r [W];
  logic [W-1:0]       sqv_r;
  mid_t               sbq;
  logic signed [W:0]  nh, sqx;
  logic signed [W:0]  numn_r, numf_r;
  mid_t               sbn_r;
  logic               vn_r;
  logic signed [31:0] tn, tf;
  mid_t               dvd_r [TDIV_LAT];
  logic [TDIV_LAT-1:0] dvv_r;
  mid_t               sbd;
  logic               nok, fok;

  // back end
  logic               v7_r, v8_r, v9_r, v10_r, v11_r, v12_r;
  logic               hit7_r, hit8_r, hit9_r;
  logic signed [31:0] t7_r, t8_r, t9_r;
  ray_t               ray7_r, ray8_r, ray9_r;
  logic signed [63:0] td8_r [3];
  sw_t                p9_r [3];
  logic signed [W:0]  dn10_r [3];
  back_t              b10_r, b11_r, b12_r;
  logic [W:0]         ndmag [3];
  logic               nfar_c [3];
  logic [RW-1:0]      nrem_r [3][FRAC_BITS+1];
  logic [FRAC_BITS-1:0] nq_r [3][FRAC_BITS+1];
  logic               nfar_r [3][FRAC_BITS+1];
  logic               nneg_r [3][FRAC_BITS+1];
  logic               nnz_r  [3][FRAC_BITS+1];
  back_t              nbd_r [FRAC_BITS+1];
  logic [FRAC_BITS:0] nbv_r;
  logic signed [FRAC_BITS+1:0] n_nxt [3];
  logic signed [FRAC_BITS+1:0] n11_r [3], n12_r [3];
  logic signed [FRAC_BITS+33:0] fp12_r [3];
  logic signed [FRAC_BITS+35:0] facing;
  logic               ff;

  logic               out_valid_r, out_hit_r, out_front_r;
  logic signed [31:0] out_t_r;
  logic signed [31:0] out_p_r [3];
  logic signed [17:0] out_n_r [3];

  assign en        = !out_valid_r || !out_stall;
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;

  assign cen[0] = cx_r;
  assign cen[1] = cy_r;
  assign cen[2] = cz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r  <= '0;
      cy_r  <= '0;
      cz_r  <= '0;
      rad_r <= RW'(65536);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        REG_CENTRE_X: cx_r  <= cfg_data;
        REG_CENTRE_Y: cy_r  <= cfg_data;
        REG_CENTRE_Z: cz_r  <= cfg_data;
        REG_RADIUS:   rad_r <= cfg_data[RW-1:0];
        default: ;
      endcase
    end
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; v4_r <= 1'b0;
      v5_r <= 1'b0; v6_r <= 1'b0; sqv_r <= '0; vn_r <= 1'b0;
      dvv_r <= '0; v7_r <= 1'b0; v8_r <= 1'b0; v9_r <= 1'b0;
      v10_r <= 1'b0; nbv_r <= '0; v11_r <= 1'b0; v12_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v1_r  <= in_valid;
      v2_r  <= v1_r;
      v3_r  <= v2_r;
      v4_r  <= v3_r;
      v5_r  <= v4_r;
      v6_r  <= v5_r;
      sqv_r <= {sqv_r[W-2:0], v6_r};
      vn_r  <= sqv_r[W-1];
      dvv_r <= {dvv_r[TDIV_LAT-2:0], vn_r};
      v7_r  <= dvv_r[TDIV_LAT-1];
      v8_r  <= v7_r;
      v9_r  <= v8_r;
      v10_r <= v9_r;
      nbv_r <= {nbv_r[FRAC_BITS-1:0], v10_r};
      v11_r <= nbv_r[FRAC_BITS];
      v12_r <= v11_r;
      out_valid_r <= v12_r;
    end
  end

  // A = D.D, H = D.M, C = M.M - r*r
  assign ray_in.o    = {in_origin_z, in_origin_y, in_origin_x};
  assign ray_in.d    = {in_dir_z, in_dir_y, in_dir_x};
  assign ray_in.tmin = in_t_min;
  assign ray_in.tmax = in_t_max;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mmag[i] = m1_r[i][32] ? $unsigned(-m1_r[i]) : $unsigned(m1_r[i]);
    end
  end

  assign a_nxt = W'(dd2_r[0] >> FRAC_BITS) + W'(dd2_r[1] >> FRAC_BITS)
               + W'(dd2_r[2] >> FRAC_BITS);
  assign h_nxt = sw_t'(dm2_r[0] >>> FRAC_BITS) + sw_t'(dm2_r[1] >>> FRAC_BITS)
               + sw_t'(dm2_r[2] >>> FRAC_BITS);
  assign msq   = W'(mm2_r[0] >> FRAC_BITS) + W'(mm2_r[1] >> FRAC_BITS)
               + W'(mm2_r[2] >> FRAC_BITS);
  assign cc_nxt = $signed(msq) - $signed(W'(rr2_r >> FRAC_BITS));

  assign habs = h3_r[W-1] ? $unsigned(-h3_r) : $unsigned(h3_r);
  assign cabs = cc3_r[W-1] ? $unsigned(-cc3_r) : $unsigned(cc3_r);
  assign h_lo = habs[HW-1:0];
  assign h_hi = HW'(habs >> HW);
  assign a_lo = a3_r[HW-1:0];
  assign a_hi = HW'(a3_r >> HW);
  assign c_lo = cabs[HW-1:0];
  assign c_hi = HW'(cabs >> HW);

  always_ff @(posedge clk) begin
    if (en) begin
      ray1_r <= ray_in;
      for (int i = 0; i < 3; i++) begin
        m1_r[i] <= $signed({ray_in.o[i][31], ray_in.o[i]}) - $signed({cen[i][31], cen[i]});
      end

      ray2_r <= ray1_r;
      for (int i = 0; i < 3; i++) begin
        dd2_r[i] <= $signed(ray1_r.d[i]) * $signed(ray1_r.d[i]);
        dm2_r[i] <= $signed({ray1_r.d[i][31], ray1_r.d[i]}) * m1_r[i];
        mm2_r[i] <= {33'd0, mmag[i]} * {33'd0, mmag[i]};
      end
      rr2_r <= {31'd0, rad_r} * {31'd0, rad_r};

      ray3_r <= ray2_r;
      a3_r   <= a_nxt;
      h3_r   <= h_nxt;
      cc3_r  <= cc_nxt;

      // split H*H and A*C into half-width partial products
      ray4_r   <= ray3_r;
      a4_r     <= a3_r;
      h4_r     <= h3_r;
      apos4_r  <= |a3_r;
      ccpos4_r <= !cc3_r[W-1] && (|cc3_r);
      hll4_r   <= (2*HW)'(h_lo) * (2*HW)'(h_lo);
      hlh4_r   <= (2*HW)'(h_lo) * (2*HW)'(h_hi);
      hhh4_r   <= (2*HW)'(h_hi) * (2*HW)'(h_hi);
      all4_r   <= (2*HW)'(a_lo) * (2*HW)'(c_lo);
      alh4_r   <= (2*HW)'(a_lo) * (2*HW)'(c_hi);
      ahl4_r   <= (2*HW)'(a_hi) * (2*HW)'(c_lo);
      ahh4_r   <= (2*HW)'(a_hi) * (2*HW)'(c_hi);

      ray5_r   <= ray4_r;
      a5_r     <= a4_r;
      h5_r     <= h4_r;
      apos5_r  <= apos4_r;
      ccpos5_r <= ccpos4_r;
      hh5_r <= QW'(hll4_r) + (QW'(hlh4_r) << (HW + 1)) + (QW'(hhh4_r) << (2 * HW));
      ac5_r <= QW'(all4_r) + ((QW'(alh4_r) + QW'(ahl4_r)) << HW)
             + (QW'(ahh4_r) << (2 * HW));

      sb6_r.miss <= !apos5_r || (ccpos5_r && (hh5_r < ac5_r));
      sb6_r.a    <= a5_r;
      sb6_r.h    <= h5_r;
      sb6_r.ray  <= ray5_r;
      disc6_r    <= ccpos5_r ? PW'(hh5_r - ac5_r) : PW'(hh5_r + ac5_r);
    end
  end

  rsi_sqrt u_sqrt (
    .clk  (clk),
    .en   (en),
    .rad  (disc6_r),
    .root (sq)
  );

  assign sbq = sqd_r[W-1];
  assign nh  = -$signed({sbq.h[W-1], sbq.h});
  assign sqx = $signed({1'b0, sq});

  always_ff @(posedge clk) begin
    if (en) begin
      sqd_r[0] <= sb6_r;
      for (int k = 1; k < W; k++) begin
        sqd_r[k] <= sqd_r[k-1];
      end
      numn_r <= nh - sqx;
      numf_r <= nh + sqx;
      sbn_r  <= sbq;
      dvd_r[0] <= sbn_r;
      for (int k = 1; k < TDIV_LAT; k++) begin
        dvd_r[k] <= dvd_r[k-1];
      end
    end
  end

  rsi_tdiv u_near (
    .clk (clk),
    .en  (en),
    .num (numn_r),
    .den (sbn_r.a),
    .t   (tn)
  );

  rsi_tdiv u_far (
    .clk (clk),
    .en  (en),
    .num (numf_r),
    .den (sbn_r.a),
    .t   (tf)
  );

  assign sbd = dvd_r[TDIV_LAT-1];
  assign nok = (tn >= $signed(sbd.ray.tmin)) && (tn <= $signed(sbd.ray.tmax));
  assign fok = (tf >= $signed(sbd.ray.tmin)) && (tf <= $signed(sbd.ray.tmax));

  // normal: (p - c) / r, one quotient bit per stage, saturating at +-1
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ndmag[i]  = dn10_r[i][W] ? $unsigned(-dn10_r[i]) : $unsigned(dn10_r[i]);
      nfar_c[i] = ndmag[i] >= {{(W + 1 - RW){1'b0}}, rad_r};
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (nfar_r[i][FRAC_BITS]) begin
        if (!nnz_r[i][FRAC_BITS]) begin
          n_nxt[i] = '0;
        end else begin
          n_nxt[i] = nneg_r[i][FRAC_BITS] ? -N_ONE : N_ONE;
        end
      end else begin
        n_nxt[i] = nneg_r[i][FRAC_BITS] ? -$signed({2'b00, nq_r[i][FRAC_BITS]})
                                         : $signed({2'b00, nq_r[i][FRAC_BITS]});
      end
    end
  end

  assign facing = (FRAC_BITS + 36)'(fp12_r[0]) + (FRAC_BITS + 36)'(fp12_r[1])
                + (FRAC_BITS + 36)'(fp12_r[2]);
  assign ff = facing[FRAC_BITS+35];

  always_ff @(posedge clk) begin : p_back
    logic [RW:0] rsh;
    logic        ge;
    if (en) begin
      hit7_r <= !sbd.miss && (nok || fok);
      t7_r   <= nok ? tn : tf;
      ray7_r <= sbd.ray;

      hit8_r <= hit7_r;
      t8_r   <= t7_r;
      ray8_r <= ray7_r;
      for (int i = 0; i < 3; i++) begin
        td8_r[i] <= t7_r * $signed(ray7_r.d[i]);
      end

      hit9_r <= hit8_r;
      t9_r   <= t8_r;
      ray9_r <= ray8_r;
      for (int i = 0; i < 3; i++) begin
        p9_r[i] <= sw_t'($signed(ray8_r.o[i])) + sw_t'(td8_r[i] >>> FRAC_BITS);
      end

      b10_r.hit <= hit9_r;
      b10_r.t   <= t9_r;
      b10_r.d   <= ray9_r.d;
      for (int i = 0; i < 3; i++) begin
        dn10_r[i]  <= $signed({p9_r[i][W-1], p9_r[i]})
                    - $signed({{(W - 31){cen[i][31]}}, cen[i]});
        b10_r.p[i] <= sat32(p9_r[i]);
      end

      nbd_r[0] <= b10_r;
      for (int k = 1; k <= FRAC_BITS; k++) begin
        nbd_r[k] <= nbd_r[k-1];
      end
      for (int i = 0; i < 3; i++) begin
        nrem_r[i][0] <= ndmag[i][RW-1:0];
        nq_r[i][0]   <= '0;
        nfar_r[i][0] <= nfar_c[i];
        nneg_r[i][0] <= dn10_r[i][W];
        nnz_r[i][0]  <= |dn10_r[i];
        for (int k = 1; k <= FRAC_BITS; k++) begin
          rsh = {nrem_r[i][k-1], 1'b0};
          ge  = rsh >= {1'b0, rad_r};
          nrem_r[i][k] <= ge ? RW'(rsh - {1'b0, rad_r}) : RW'(rsh);
          nq_r[i][k]   <= {nq_r[i][k-1][FRAC_BITS-2:0], ge};
          nfar_r[i][k] <= nfar_r[i][k-1];
          nneg_r[i][k] <= nneg_r[i][k-1];
          nnz_r[i][k]  <= nnz_r[i][k-1];
        end
      end

      b11_r <= nbd_r[FRAC_BITS];
      for (int i = 0; i < 3; i++) begin
        n11_r[i] <= n_nxt[i];
      end

      b12_r <= b11_r;
      for (int i = 0; i < 3; i++) begin
        n12_r[i]  <= n11_r[i];
        fp12_r[i] <= $signed(b11_r.d[i]) * n11_r[i];
      end

      out_hit_r   <= b12_r.hit;
      out_front_r <= b12_r.hit && ff;
      out_t_r     <= b12_r.hit ? $signed(b12_r.t) : 32'sd0;
      for (int i = 0; i < 3; i++) begin
        out_p_r[i] <= b12_r.hit ? $signed(b12_r.p[i]) : 32'sd0;
        out_n_r[i] <= !b12_r.hit ? 18'sd0 : (ff ? 18'(n12_r[i]) : 18'(-n12_r[i]));
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_hit_found  = out_hit_r;
  assign out_front_face = out_front_r;
  assign out_t_hit      = out_t_r;
  assign out_point_x    = out_p_r[0];
  assign out_point_y    = out_p_r[1];
  assign out_point_z    = out_p_r[2];
  assign out_normal_x   = out_n_r[0];
  assign out_normal_y   = out_n_r[1];
  assign out_normal_z   = out_n_r[2];

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit_found |-> out_t_hit == 32'sd0 && !out_front_face
      && out_normal_x == 18'sd0 && out_normal_y == 18'sd0 && out_normal_z == 18'sd0)
    else $error("miss carries non-zero fields");

  a_t_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    v7_r && hit7_r |-> t7_r >= $signed(ray7_r.tmin) && t7_r <= $signed(ray7_r.tmax))
    else $error("hit t outside interval");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(v7_r) && $stable(t7_r) && $stable(vn_r))
    else $error("pipe moved while output stalled");

endmodule
